/* rtl/prct_pkg.sv */
`timescale 1ns / 1ps

package prct_pkg;

    // Table geometry.
    localparam int unsigned CLUSTER_COUNT     = 16;
    localparam int unsigned PAGES_PER_CLUSTER = 64;
    localparam int unsigned COUNT_WIDTH       = 16;

    // Fixed field widths.
    localparam int unsigned OP_W        = 2;
    localparam int unsigned PAGE_W      = 10;
    localparam int unsigned OUT_CNT_W   = 16;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned PAGE_SPACE  = 1 << PAGE_W;

    // Derived sizes.
    localparam int unsigned TOTAL_PAGES = CLUSTER_COUNT * PAGES_PER_CLUSTER;
    localparam int unsigned MEM_DEPTH   = (TOTAL_PAGES < PAGE_SPACE) ? TOTAL_PAGES : PAGE_SPACE;
    localparam int unsigned MEM_AW      = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int unsigned CL_W        = (CLUSTER_COUNT > 1) ? $clog2(CLUSTER_COUNT) : 1;
    localparam int unsigned NZ_W        = $clog2(PAGES_PER_CLUSTER + 1);

    typedef enum logic [OP_W-1:0] {
        OP_READ = 2'd0,
        OP_ADD  = 2'd1,
        OP_DROP = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_ABSENT    = 2'd1,
        ST_ZERO      = 2'd2,
        ST_SATURATED = 2'd3
    } t_status;

endpackage

/* rtl/page_reference_count_table.sv */
// An accepted request goes into stage one, where its count memory read is registered;
// it then moves into the output register, with o_valid high, once that register is free.
// Throughput: one request per cycle while o_stall is low; the count memory read is
// registered, and the count read-modify-write and cluster counter update happen in stage one.
// Reset (synchronous, active low) clears control state and the cluster counters, then
// a clearing pass zeroes the count memory, one entry per cycle, over all MEM_DEPTH (1024)
// entries; o_stall stays high for that whole pass.
`timescale 1ns / 1ps

module page_reference_count_table import prct_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [OP_W-1:0]      i_operation,
    input  logic [PAGE_W-1:0]    i_page_number,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [OUT_CNT_W-1:0] o_count_after,
    output logic [STATUS_W-1:0]  o_status,
    output logic                 o_cluster_present
);

    // The count memory. It has no reset; the clearing pass after reset zeroes it.
    logic [COUNT_WIDTH-1:0] mem [MEM_DEPTH];
    logic [COUNT_WIDTH-1:0] r_rd_data;

    // Clearing pass state.
    logic              r_clr_busy;
    logic [MEM_AW-1:0] r_clr_addr;

    // Number of nonzero counts in each cluster. A cluster is present while its
    // counter is nonzero.
    logic [NZ_W-1:0] r_nz [CLUSTER_COUNT];

    // Stage one: the request whose count has just been read.
    logic                   r_s1_valid;
    logic [OP_W-1:0]        r_s1_op;
    logic [PAGE_W-1:0]      r_s1_page;
    logic                   r_s1_fwd;
    logic [COUNT_WIDTH-1:0] r_s1_fwd_data;

    // Handshake.
    logic in_accept;
    logic s1_adv;

    // Stage one datapath.
    logic                   w_in_range;
    logic [PAGE_W-1:0]      w_cl_full;
    logic [CL_W-1:0]        w_cl;
    logic [COUNT_WIDTH-1:0] w_cur;
    logic [NZ_W-1:0]        w_nz;
    logic [COUNT_WIDTH-1:0] w_cnt;
    logic [NZ_W-1:0]        w_nz_next;
    logic                   w_nz_we;
    logic                   w_cnt_we;
    t_status                w_status;
    logic                   w_present;
    logic [32:0]            w_cnt_ext;

    // Memory write port, shared by the clearing pass and stage one.
    logic                   w_mem_we;
    logic [MEM_AW-1:0]      w_mem_addr;
    logic [COUNT_WIDTH-1:0] w_mem_data;
    logic                   w_s1_wr;

    // Stage one moves into the output register whenever that register is empty
    // or being emptied this cycle.
    assign s1_adv    = !o_valid || !i_stall;
    assign o_stall   = r_clr_busy || (r_s1_valid && !s1_adv);
    assign in_accept = i_valid && !o_stall;

    // Frame index and cluster index of the request in stage one. A frame past the
    // end of the table has no storage at all.
    assign w_in_range = 32'(r_s1_page) < TOTAL_PAGES;
    assign w_cl_full  = PAGE_W'(32'(r_s1_page) / PAGES_PER_CLUSTER);
    assign w_cl       = w_cl_full[CL_W-1:0];

    // The memory read happens in the same cycle as the write of the request ahead,
    // so the read data may be one write old; the captured write value wins then.
    assign w_cur = r_s1_fwd ? r_s1_fwd_data : r_rd_data;
    assign w_nz  = r_nz[w_cl];

    always_comb begin
        w_cnt     = w_cur;
        w_nz_next = w_nz;
        w_nz_we   = 1'b0;
        w_cnt_we  = 1'b0;
        w_status  = ST_OK;
        unique case (r_s1_op)
            OP_ADD: begin
                if (w_cur == {COUNT_WIDTH{1'b1}}) begin
                    // Saturated: the count stays at its maximum.
                    w_status = ST_SATURATED;
                end else begin
                    w_cnt    = w_cur + COUNT_WIDTH'(1);
                    w_cnt_we = 1'b1;
                    if (w_cur == '0) begin
                        w_nz_next = w_nz + NZ_W'(1);
                        w_nz_we   = 1'b1;
                    end
                end
            end
            OP_DROP: begin
                if (w_nz == '0) begin
                    // Nothing in this cluster holds a reference.
                    w_status = ST_ABSENT;
                    w_cnt    = '0;
                end else if (w_cur == '0) begin
                    w_status = ST_ZERO;
                end else begin
                    w_cnt    = w_cur - COUNT_WIDTH'(1);
                    w_cnt_we = 1'b1;
                    if (w_cur == COUNT_WIDTH'(1)) begin
                        w_nz_next = w_nz - NZ_W'(1);
                        w_nz_we   = 1'b1;
                    end
                end
            end
            default: begin
                // A read, and the unused operation code, change nothing.
            end
        endcase
        w_present = (w_nz_we ? w_nz_next : w_nz) != '0;

        // A frame past the end of the table: no update, count zero, cluster absent.
        if (!w_in_range) begin
            w_cnt     = '0;
            w_nz_we   = 1'b0;
            w_cnt_we  = 1'b0;
            w_present = 1'b0;
            w_status  = ((r_s1_op == OP_ADD) || (r_s1_op == OP_DROP)) ? ST_ABSENT : ST_OK;
        end
    end

    assign w_cnt_ext = 33'(w_cnt);
    assign w_s1_wr   = r_s1_valid && s1_adv && w_cnt_we;

    always_comb begin
        if (r_clr_busy) begin
            w_mem_we   = 1'b1;
            w_mem_addr = r_clr_addr;
            w_mem_data = '0;
        end else begin
            w_mem_we   = w_s1_wr;
            w_mem_addr = r_s1_page[MEM_AW-1:0];
            w_mem_data = w_cnt;
        end
    end

    // Count memory: one write port, one registered read port. The read is taken
    // only on an accepted request, so the data holds while stage one waits.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[w_mem_addr] <= w_mem_data;
        end
        if (in_accept) begin
            r_rd_data <= mem[i_page_number[MEM_AW-1:0]];
        end
    end

    // Clearing pass after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + MEM_AW'(1);
            if (r_clr_addr == MEM_AW'(MEM_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Cluster counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CLUSTER_COUNT; k++) begin
                r_nz[k] <= '0;
            end
        end else if (r_s1_valid && s1_adv && w_nz_we) begin
            r_nz[w_cl] <= w_nz_next;
        end
    end

    // Stage one control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Stage one payload, including the value of a write to the same frame that
    // lands in the very cycle of the memory read.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_op       <= i_operation;
            r_s1_page     <= i_page_number;
            r_s1_fwd      <= w_s1_wr && (r_s1_page == i_page_number);
            r_s1_fwd_data <= w_cnt;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (s1_adv) begin
            o_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && s1_adv) begin
            o_count_after     <= w_cnt_ext[OUT_CNT_W-1:0];
            o_status          <= w_status;
            o_cluster_present <= w_present;
        end
    end

`ifndef ASSERT_OFF
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !in_accept)
        else $error("request accepted during the clearing pass");

    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && s1_adv) |=> o_valid)
        else $error("stage one result lost on its way to the output register");

    a_absent_not_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_ABSENT)) |-> (!o_cluster_present && (o_count_after == '0)))
        else $error("absent status with a present cluster or a nonzero count");

    a_zero_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_ZERO)) |-> (o_cluster_present && (o_count_after == '0)))
        else $error("zero count status inconsistent with cluster state");

    a_sat_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_SATURATED)) |-> o_cluster_present)
        else $error("saturated count in an absent cluster");
`endif

endmodule
